>>> rtl/wft_pkg.sv
// Shared types, codes and constants of the waypoint follower.
package wft_pkg;

	localparam int TGT_W = 5;
	localparam int ITER_W = 5;
	localparam int DIFF_W = 33;
	localparam int CX_W = 37;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [2:0] {
		CMD_ODOM  = 3'd0,
		CMD_TICK  = 3'd1,
		CMD_START = 3'd2,
		CMD_STOP  = 3'd3,
		CMD_WRITE = 3'd4
	} command_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_ANGULAR_SPEED   = 3'd0,
		REG_LINEAR_SPEED    = 3'd1,
		REG_ANGLE_TOLERANCE = 3'd2,
		REG_ARRIVE_DISTANCE = 3'd3,
		REG_WAYPOINT_COUNT  = 3'd4
	} reg_index_t;

	typedef enum logic [2:0] {
		MODE_INIT   = 3'd0,
		MODE_WAIT   = 3'd1,
		MODE_FOLLOW = 3'd2,
		MODE_CHANGE = 3'd3,
		MODE_STOP   = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		KIND_VELOCITY = 2'd0,
		KIND_RESET    = 2'd1,
		KIND_FINISHED = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		EMIT_TURN,
		EMIT_DRIVE,
		EMIT_RESET,
		EMIT_FINISHED
	} emit_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_A,
		SQ_B,
		SQ_C
	} sq_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT_RD,
		S_INIT_LD,
		S_RD,
		S_DIFF,
		S_PRE,
		S_CORD,
		S_ERR,
		S_SQA,
		S_SQB,
		S_SQC,
		S_CMP,
		S_EMIT
	} seq_t;

	typedef struct packed {
		logic   ram_we;
		logic   rd_home;
		logic   load_pose;
		logic   load_home;
		logic   load_diff;
		logic   cordic_init;
		logic   cordic_step;
		sq_op_t sq_op;
		logic   out_load;
		emit_t  emit_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic turn;
		logic far;
		logic cordic_last;
	} dp_stat_t;

	// Arctangent of 2^-i as a fraction of a full turn of 2^32.
	function automatic logic [31:0] atan_step(input logic [ITER_W-1:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10679838;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/wft_if.sv
// Channel interfaces of the waypoint follower: requests, results and configuration.
interface wft_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         command;
	logic signed [31:0] pose_x;
	logic signed [31:0] pose_y;
	logic signed [15:0] pose_heading;
	logic [3:0]         waypoint_slot;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;

	modport source (output valid, command, pose_x, pose_y, pose_heading, waypoint_slot,
		point_x, point_y, input ready);
	modport sink (input valid, command, pose_x, pose_y, pose_heading, waypoint_slot,
		point_x, point_y, output ready);
endinterface

interface wft_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [15:0] turn_rate;
	logic [14:0]        forward_speed;
	logic signed [31:0] reset_x;
	logic signed [31:0] reset_y;

	modport source (output valid, kind, turn_rate, forward_speed, reset_x, reset_y,
		input ready);
	modport sink (input valid, kind, turn_rate, forward_speed, reset_x, reset_y,
		output ready);
endinterface

interface wft_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  addr;
	logic [31:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

>>> rtl/wft_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wft_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

>>> rtl/wft_dp.sv
// Datapath: pose registers, route memory, CORDIC bearing, distance check, result register.
module wft_dp #(
	parameter int MAX_WAYPOINTS = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wft_pkg::dp_cmd_t           cmd,
	output wft_pkg::dp_stat_t          stat,
	input  logic [wft_pkg::TGT_W-1:0]  target,
	input  logic signed [31:0]         pose_x,
	input  logic signed [31:0]         pose_y,
	input  logic signed [15:0]         pose_heading,
	input  logic [3:0]                 waypoint_slot,
	input  logic signed [31:0]         point_x,
	input  logic signed [31:0]         point_y,
	input  logic [14:0]                angular_speed,
	input  logic [14:0]                linear_speed,
	input  logic [14:0]                angle_tolerance,
	input  logic [30:0]                arrive_distance,
	output logic [1:0]                 kind,
	output logic signed [15:0]         turn_rate,
	output logic [14:0]                forward_speed,
	output logic signed [31:0]         reset_x,
	output logic signed [31:0]         reset_y
);
	import wft_pkg::*;

	localparam int AW = $clog2(MAX_WAYPOINTS);

	logic [AW-1:0]             raddr;
	logic [63:0]               rdata;
	logic                      tbl_ok_q;
	logic signed [31:0]        wx, wy;
	logic signed [31:0]        cur_x_q, cur_y_q;
	logic [15:0]               cur_h_q;
	logic signed [DIFF_W-1:0]  dx_q, dy_q;
	logic signed [CX_W-1:0]    cx_q, cy_q, dxe, dye, xs, ys;
	logic [31:0]               z_q, zr;
	logic [ITER_W-1:0]         it_q;
	logic                      zv_q;
	logic [15:0]               brg;
	logic signed [15:0]        err;
	logic signed [16:0]        e17, mag;
	logic                      epos;
	logic [DIFF_W-1:0]         ax, ay;
	logic                      big;
	logic [30:0]               mul_a;
	logic [61:0]               prod_q;
	logic [62:0]               acc_q;
	logic [1:0]                kind_q;
	logic signed [15:0]        tr_q;
	logic [14:0]               fwd_q;
	logic signed [31:0]        rx_q, ry_q;

	assign raddr = cmd.rd_home ? '0 : AW'(target);

	wft_ram #(.WIDTH(64), .DEPTH(MAX_WAYPOINTS)) u_route (
		.clk   (clk),
		.we    (cmd.ram_we && (32'(waypoint_slot) < MAX_WAYPOINTS)),
		.waddr (AW'(waypoint_slot)),
		.wdata ({point_x, point_y}),
		.raddr (raddr),
		.rdata (rdata)
	);

	// A target slot beyond the table reads as the origin.
	always_ff @(posedge clk) begin
		tbl_ok_q <= cmd.rd_home || (32'(target) < MAX_WAYPOINTS);
	end

	assign wx = tbl_ok_q ? signed'(rdata[63:32]) : '0;
	assign wy = tbl_ok_q ? signed'(rdata[31:0]) : '0;

	// The pose starts at the origin with heading zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			cur_h_q <= '0;
		end else if (cmd.load_pose) begin
			cur_x_q <= pose_x;
			cur_y_q <= pose_y;
			cur_h_q <= pose_heading;
		end else if (cmd.load_home) begin
			cur_x_q <= wx;
			cur_y_q <= wy;
			cur_h_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_diff) begin
			dx_q <= DIFF_W'(wx) - DIFF_W'(cur_x_q);
			dy_q <= DIFF_W'(wy) - DIFF_W'(cur_y_q);
		end
	end

	// CORDIC in vectoring mode; a left-half vector is first turned by a quarter.
	assign dxe = CX_W'(dx_q);
	assign dye = CX_W'(dy_q);
	assign xs = cx_q >>> it_q;
	assign ys = cy_q >>> it_q;

	always_ff @(posedge clk) begin
		if (cmd.cordic_init) begin
			it_q <= '0;
			zv_q <= (dx_q == '0) && (dy_q == '0);
			if (dx_q[DIFF_W-1] && !dy_q[DIFF_W-1]) begin
				cx_q <= dye;
				cy_q <= -dxe;
				z_q  <= 32'h4000_0000;
			end else if (dx_q[DIFF_W-1]) begin
				cx_q <= -dye;
				cy_q <= dxe;
				z_q  <= 32'hC000_0000;
			end else begin
				cx_q <= dxe;
				cy_q <= dye;
				z_q  <= '0;
			end
		end else if (cmd.cordic_step) begin
			it_q <= it_q + 1'b1;
			if (!cy_q[CX_W-1]) begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				z_q  <= z_q + atan_step(it_q);
			end else begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				z_q  <= z_q - atan_step(it_q);
			end
		end
	end

	assign zr = z_q + 32'h0000_8000;
	assign brg = zv_q ? 16'd0 : zr[31:16];
	assign err = signed'(cur_h_q - brg);
	assign e17 = 17'(err);
	assign mag = e17[16] ? -e17 : e17;
	assign epos = !err[15] && (err != 16'sd0);

	// Any axis distance of 2^31 or more is surely beyond the arrival radius.
	assign ax = dx_q[DIFF_W-1] ? unsigned'(-dx_q) : unsigned'(dx_q);
	assign ay = dy_q[DIFF_W-1] ? unsigned'(-dy_q) : unsigned'(dy_q);
	assign big = (ax[32:31] != 2'b00) || (ay[32:31] != 2'b00);

	always_comb begin
		unique case (cmd.sq_op)
			SQ_A:    mul_a = ax[30:0];
			SQ_B:    mul_a = ay[30:0];
			SQ_C:    mul_a = arrive_distance;
			default: mul_a = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.sq_op != SQ_IDLE) begin
			prod_q <= mul_a * mul_a;
		end
		if (cmd.sq_op == SQ_B) begin
			acc_q <= 63'(prod_q);
		end else if (cmd.sq_op == SQ_C) begin
			acc_q <= acc_q + 63'(prod_q);
		end
	end

	assign stat.turn = mag >= 17'(angle_tolerance);
	assign stat.far = big || (acc_q > 63'(prod_q));
	assign stat.cordic_last = (it_q == ITER_W'(CORDIC_STEPS - 1));

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			kind_q <= KIND_VELOCITY;
			tr_q   <= '0;
			fwd_q  <= '0;
			rx_q   <= '0;
			ry_q   <= '0;
			unique case (cmd.emit_sel)
				EMIT_TURN: begin
					tr_q <= epos ? -signed'({1'b0, angular_speed})
						: signed'({1'b0, angular_speed});
				end
				EMIT_DRIVE: begin
					fwd_q <= linear_speed;
				end
				EMIT_RESET: begin
					kind_q <= KIND_RESET;
					rx_q   <= cur_x_q;
					ry_q   <= cur_y_q;
				end
				EMIT_FINISHED: begin
					kind_q <= KIND_FINISHED;
				end
			endcase
		end
	end

	assign kind = kind_q;
	assign turn_rate = tr_q;
	assign forward_speed = fwd_q;
	assign reset_x = rx_q;
	assign reset_y = ry_q;
endmodule

>>> rtl/wft_ctrl.sv
// Controller: mode machine, target bookkeeping, sequencing of the datapath and result valid.
module wft_ctrl #(
	parameter int MAX_WAYPOINTS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [2:0]                command,
	output logic                      out_valid,
	input  logic                      out_ready,
	input  logic [4:0]                waypoint_count,
	input  wft_pkg::dp_stat_t         stat,
	output wft_pkg::dp_cmd_t          cmd,
	output logic [wft_pkg::TGT_W-1:0] target
);
	import wft_pkg::*;

	seq_t              st_q, st_d;
	mode_t             mode_q, mode_d;
	logic [TGT_W-1:0]  target_q, target_d;
	logic              av_q, av_d;
	emit_t             emit_q, emit_d;
	logic              ov_q, ov_d;
	logic              accept;
	logic              tick;
	logic              slot_free;
	logic [TGT_W:0]    next_slot;
	logic [31:0]       used;

	assign accept = in_valid && (st_q == S_IDLE);
	assign tick = accept && (command == CMD_TICK);
	assign slot_free = !ov_q || out_ready;
	assign next_slot = {1'b0, target_q} + 1'b1;

	always_comb begin
		if (waypoint_count < 5'd2) begin
			used = 32'd2;
		end else if (32'(waypoint_count) > MAX_WAYPOINTS) begin
			used = 32'(MAX_WAYPOINTS);
		end else begin
			used = 32'(waypoint_count);
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE: begin
				if (tick) begin
					priority case (mode_q)
						MODE_INIT:   st_d = S_INIT_RD;
						MODE_FOLLOW: st_d = S_RD;
						MODE_STOP:   st_d = S_EMIT;
						default:     st_d = S_IDLE;
					endcase
				end
			end
			S_INIT_RD: st_d = S_INIT_LD;
			S_INIT_LD: st_d = S_EMIT;
			S_RD:      st_d = S_DIFF;
			S_DIFF:    st_d = S_PRE;
			S_PRE:     st_d = S_CORD;
			S_CORD:    st_d = stat.cordic_last ? S_ERR : S_CORD;
			S_ERR:     st_d = stat.turn ? S_EMIT : S_SQA;
			S_SQA:     st_d = S_SQB;
			S_SQB:     st_d = S_SQC;
			S_SQC:     st_d = S_CMP;
			S_CMP:     st_d = stat.far ? S_EMIT : S_IDLE;
			S_EMIT:    st_d = slot_free ? S_IDLE : S_EMIT;
			default:   st_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.sq_op = SQ_IDLE;
		cmd.emit_sel = emit_q;
		mode_d = mode_q;
		target_d = target_q;
		av_d = av_q;
		emit_d = emit_q;
		ov_d = (ov_q && !out_ready);
		in_ready = (st_q == S_IDLE);

		unique case (st_q)
			S_IDLE: begin
				if (accept) begin
					priority case (command)
						CMD_ODOM:  cmd.load_pose = 1'b1;
						CMD_START: mode_d = MODE_FOLLOW;
						CMD_STOP:  mode_d = MODE_STOP;
						CMD_WRITE: cmd.ram_we = 1'b1;
						CMD_TICK: begin
							if (mode_q == MODE_STOP) begin
								emit_d = EMIT_FINISHED;
							end else if (mode_q == MODE_CHANGE) begin
								if (av_q) begin
									mode_d = MODE_STOP;
									target_d = next_slot[TGT_W-1:0];
								end else if (32'(next_slot) >= used) begin
									target_d = '0;
									av_d = 1'b1;
									mode_d = MODE_FOLLOW;
								end else begin
									target_d = next_slot[TGT_W-1:0];
									mode_d = MODE_FOLLOW;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_INIT_RD: cmd.rd_home = 1'b1;
			S_INIT_LD: begin
				cmd.load_home = 1'b1;
				target_d = TGT_W'(1);
				mode_d = MODE_WAIT;
				emit_d = EMIT_RESET;
			end
			S_DIFF:    cmd.load_diff = 1'b1;
			S_PRE:     cmd.cordic_init = 1'b1;
			S_CORD:    cmd.cordic_step = 1'b1;
			S_ERR:     emit_d = EMIT_TURN;
			S_SQA:     cmd.sq_op = SQ_A;
			S_SQB:     cmd.sq_op = SQ_B;
			S_SQC:     cmd.sq_op = SQ_C;
			S_CMP: begin
				emit_d = EMIT_DRIVE;
				if (!stat.far) begin
					mode_d = MODE_CHANGE;
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					ov_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			mode_q   <= MODE_INIT;
			target_q <= '0;
			av_q     <= 1'b0;
			emit_q   <= EMIT_TURN;
			ov_q     <= 1'b0;
		end else begin
			st_q     <= st_d;
			mode_q   <= mode_d;
			target_q <= target_d;
			av_q     <= av_d;
			emit_q   <= emit_d;
			ov_q     <= ov_d;
		end
	end

	assign out_valid = ov_q;
	assign target = target_q;
endmodule

>>> rtl/waypoint_follower_turn_then_drive.sv
// Top level of the turn-then-drive waypoint follower.
//
// The block has three channels. The req channel carries one command item:
// odometry, tick, start, stop or a waypoint write. The res channel returns at
// most one result item per tick: a velocity command, a pose reset, or a
// finished notice. The cfg channel writes the five setup registers and is
// always ready; it should only be written while the block is idle.
//
// Odometry, start, stop and write items are taken while the block is idle,
// and the block stays ready after them. A tick while following reads the
// target waypoint from the route RAM, forms the offset, runs the CORDIC unit,
// and then either turns or goes on to the squared distance check through one
// shared multiplier. A first tick reads slot 0 of the route RAM as the home
// pose and emits a pose reset.
//
// Reset clears the mode to initialise, the target to slot 0 and the registers
// to their defaults; the route RAM holds nothing until written. The result
// sits in an output register, so the next item is accepted while it waits; if
// the receiver still stalls when a new result is ready, the block holds it.
module waypoint_follower_turn_then_drive #(
	parameter int MAX_WAYPOINTS = 16,
	parameter int CORDIC_STEPS = 16
) (
	input logic      clk,
	input logic      arst_n,
	wft_cfg_if.sink  cfg,
	wft_req_if.sink  req,
	wft_res_if.source res
);
	import wft_pkg::*;

	logic [14:0]       angular_speed_q;
	logic [14:0]       linear_speed_q;
	logic [14:0]       angle_tolerance_q;
	logic [30:0]       arrive_distance_q;
	logic [4:0]        waypoint_count_q;
	dp_cmd_t           cmd;
	dp_stat_t          stat;
	logic [TGT_W-1:0]  target;

	// The configuration port never stalls; unknown indexes are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angular_speed_q   <= '0;
			linear_speed_q    <= '0;
			angle_tolerance_q <= '0;
			arrive_distance_q <= 31'd6554;
			waypoint_count_q  <= 5'd2;
		end else if (cfg.valid) begin
			priority case (cfg.addr)
				REG_ANGULAR_SPEED:   angular_speed_q   <= cfg.data[14:0];
				REG_LINEAR_SPEED:    linear_speed_q    <= cfg.data[14:0];
				REG_ANGLE_TOLERANCE: angle_tolerance_q <= cfg.data[14:0];
				REG_ARRIVE_DISTANCE: arrive_distance_q <= cfg.data[30:0];
				REG_WAYPOINT_COUNT:  waypoint_count_q  <= cfg.data[4:0];
				default: begin
				end
			endcase
		end
	end

	// The controller sequences each item; the datapath does the pose, bearing and distance arithmetic.
	wft_ctrl #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (req.valid),
		.in_ready       (req.ready),
		.command        (req.command),
		.out_valid      (res.valid),
		.out_ready      (res.ready),
		.waypoint_count (waypoint_count_q),
		.stat           (stat),
		.cmd            (cmd),
		.target         (target)
	);

	wft_dp #(.MAX_WAYPOINTS(MAX_WAYPOINTS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.target          (target),
		.pose_x          (req.pose_x),
		.pose_y          (req.pose_y),
		.pose_heading    (req.pose_heading),
		.waypoint_slot   (req.waypoint_slot),
		.point_x         (req.point_x),
		.point_y         (req.point_y),
		.angular_speed   (angular_speed_q),
		.linear_speed    (linear_speed_q),
		.angle_tolerance (angle_tolerance_q),
		.arrive_distance (arrive_distance_q),
		.kind            (res.kind),
		.turn_rate       (res.turn_rate),
		.forward_speed   (res.forward_speed),
		.reset_x         (res.reset_x),
		.reset_y         (res.reset_y)
	);
endmodule

>>> rtl/wft_check.sv
// Port-level checks of the waypoint follower, bound to the top level.
module wft_check (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic [2:0]         req_command,
	input logic               res_valid,
	input logic               res_ready,
	input logic [1:0]         res_kind,
	input logic signed [15:0] res_turn_rate,
	input logic [14:0]        res_forward_speed
);
	import wft_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind))
		else $error("result item changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_command != CMD_TICK) && !res_valid |=> !res_valid)
		else $error("result item from a command that gives none");

	a_vel_one_axis: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == KIND_VELOCITY) |->
			(res_turn_rate == 16'sd0) || (res_forward_speed == 15'd0))
		else $error("velocity item both turns and drives");

	a_other_still: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && ((res_kind == KIND_RESET) || (res_kind == KIND_FINISHED)) |->
			(res_turn_rate == 16'sd0) && (res_forward_speed == 15'd0))
		else $error("reset or finished item carries a velocity");
endmodule

bind waypoint_follower_turn_then_drive wft_check u_wft_check (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.req_command       (req.command),
	.res_valid         (res.valid),
	.res_ready         (res.ready),
	.res_kind          (res.kind),
	.res_turn_rate     (res.turn_rate),
	.res_forward_speed (res.forward_speed)
);
